[rtl/core/population_variance_aggregate_top_defines.svh]
// ----------------------------------------------------------------------------
// Population variance aggregate - assertion macros
// Shared same-cycle-implication and next-cycle-implication property macros.
// ----------------------------------------------------------------------------
`ifndef POPULATION_VARIANCE_AGGREGATE_TOP_DEFINES_SVH
`define POPULATION_VARIANCE_AGGREGATE_TOP_DEFINES_SVH

// same-cycle implication
`define PVAG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pvag: same-cycle check failed");

// next-cycle implication
`define PVAG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pvag: next-cycle check failed");

`endif

[rtl/core/pvag_pkg.sv]
// ----------------------------------------------------------------------------
// Population variance aggregate - package
// Field widths, limits and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package pvag_pkg;

  localparam int SAMP_W    = 16;
  localparam int SUM_W     = 40;
  localparam int SQ_W      = 56;
  localparam int PCNT_W    = 24;
  localparam int VAR_W     = 31;
  localparam int PROD_W    = 2 * SUM_W;
  localparam int DIFF_W    = 63;
  localparam int MUL_STEPS = SUM_W;
  localparam int DIV_STEPS = PROD_W;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_MERGE  = 1'b1;

  localparam logic [SUM_W-1:0]  SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] Q_LIMIT = PROD_W'(64'h4000_0000_0000_0000);
  localparam logic [VAR_W-1:0]  VAR_MAX = VAR_W'(32'h4000_0000);

  typedef struct packed {
    logic accept;
    logic snap;
    logic mul_step;
    logic div_load_sq;
    logic div_load_m;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_last;
    logic cnt_zero;
  } dp_stat_t;

endpackage

[rtl/core/pvag_if.sv]
// ----------------------------------------------------------------------------
// Population variance aggregate - channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pvag_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [pvag_pkg::SAMP_W-1:0]  sample;
  logic                                sample_null;
  logic signed [pvag_pkg::SUM_W-1:0]   part_sum;
  logic        [pvag_pkg::SQ_W-1:0]    part_sumsq;
  logic        [pvag_pkg::PCNT_W-1:0]  part_count;
  logic                                last;

  modport source (
    output valid, req_type, sample, sample_null, part_sum, part_sumsq, part_count, last,
    input  ready
  );
  modport sink (
    input  valid, req_type, sample, sample_null, part_sum, part_sumsq, part_count, last,
    output ready
  );
endinterface

interface pvag_out_if;
  logic                          valid;
  logic                          ready;
  logic [pvag_pkg::VAR_W-1:0]    variance;
  logic                          no_samples;
  logic                          overflow;

  modport source (
    output valid, variance, no_samples, overflow,
    input  ready
  );
  modport sink (
    input  valid, variance, no_samples, overflow,
    output ready
  );
endinterface

[rtl/core/pvag_div.sv]
// ----------------------------------------------------------------------------
// Population variance aggregate - restoring divider
// One quotient bit per step; quotient shifts in where the dividend shifts out.
// ----------------------------------------------------------------------------
module pvag_div #(
  parameter int DVD_W = 80,
  parameter int DVS_W = 24
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient
);

  logic [DVD_W-1:0] qr;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   r_sh;
  logic [DVS_W:0]   r_sub;
  logic             fits;

  assign r_sh     = {rem, qr[DVD_W-1]};
  assign fits     = r_sh >= {1'b0, divisor};
  assign r_sub    = r_sh - {1'b0, divisor};
  assign quotient = qr;

  always_ff @(posedge clk) begin
    if (load) begin
      qr  <= dividend;
      rem <= '0;
    end else if (step) begin
      qr  <= {qr[DVD_W-2:0], fits};
      rem <= fits ? r_sub[DVS_W-1:0] : r_sh[DVS_W-1:0];
    end
  end

endmodule

[rtl/core/pvag_ctrl.sv]
// ----------------------------------------------------------------------------
// Population variance aggregate - controller
// Sequences accumulate, snapshot, square, two divides and result load.
// ----------------------------------------------------------------------------
`include "population_variance_aggregate_top_defines.svh"

module pvag_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  pvag_pkg::dp_stat_t   stat,
  output pvag_pkg::ctrl_cmd_t  cmd
);

  localparam int CNT_W = $clog2(pvag_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(pvag_pkg::MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(pvag_pkg::DIV_STEPS - 1);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_SNAP,
    ST_MUL,
    ST_DLOAD1,
    ST_DIV1,
    ST_DLOAD2,
    ST_DIV2,
    ST_LOAD
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] step_cnt;
  logic             load_ok;

  assign load_ok  = !out_valid || out_ready;
  assign in_ready = (state == ST_ACCUM) && !stat.s1_last;

  always_comb begin
    cmd             = '0;
    cmd.accept      = in_ready && in_valid;
    cmd.snap        = (state == ST_SNAP);
    cmd.mul_step    = (state == ST_MUL);
    cmd.div_load_sq = (state == ST_DLOAD1);
    cmd.div_load_m  = (state == ST_DLOAD2);
    cmd.div_step    = (state == ST_DIV1) || (state == ST_DIV2);
    cmd.load_out    = (state == ST_LOAD) && load_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_ACCUM: begin
          if (stat.s1_valid && stat.s1_last) begin
            state <= ST_SNAP;
          end
        end
        ST_SNAP: begin
          step_cnt <= '0;
          state    <= stat.cnt_zero ? ST_LOAD : ST_MUL;
        end
        ST_MUL: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == MUL_LAST) begin
            state <= ST_DLOAD1;
          end
        end
        ST_DLOAD1: begin
          step_cnt <= '0;
          state    <= ST_DIV1;
        end
        ST_DIV1: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == DIV_LAST) begin
            state <= ST_DLOAD2;
          end
        end
        ST_DLOAD2: begin
          step_cnt <= '0;
          state    <= ST_DIV2;
        end
        ST_DIV2: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == DIV_LAST) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (load_ok) begin
            state <= ST_ACCUM;
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

  `PVAG_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_ACCUM, !cmd.accept)
  `PVAG_ASSERT_NXT(a_load_shows, clk, rst, cmd.load_out, out_valid)
  `PVAG_ASSERT_NXT(a_last_snaps, clk, rst, state == ST_ACCUM && stat.s1_valid && stat.s1_last, state == ST_SNAP)
  `PVAG_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, step_cnt <= CNT_W'(pvag_pkg::DIV_STEPS))

endmodule

[rtl/core/pvag_dp.sv]
// ----------------------------------------------------------------------------
// Population variance aggregate - datapath
// Operand stage, saturating accumulators, shift-add squarer, divider, result.
// ----------------------------------------------------------------------------
`include "population_variance_aggregate_top_defines.svh"

module pvag_dp #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pvag_pkg::ctrl_cmd_t                 cmd,
  output pvag_pkg::dp_stat_t                  stat,
  input  logic                                req_type,
  input  logic signed [pvag_pkg::SAMP_W-1:0]  sample,
  input  logic                                sample_null,
  input  logic signed [pvag_pkg::SUM_W-1:0]   part_sum,
  input  logic        [pvag_pkg::SQ_W-1:0]    part_sumsq,
  input  logic        [pvag_pkg::PCNT_W-1:0]  part_count,
  input  logic                                last,
  output logic        [pvag_pkg::VAR_W-1:0]   variance,
  output logic                                no_samples,
  output logic                                overflow
);

  localparam int SX      = (SAMPLE_BITS > pvag_pkg::SAMP_W) ? SAMPLE_BITS : pvag_pkg::SAMP_W;
  localparam int SQ_BITS = 2 * SAMPLE_BITS;
  localparam int SW1     = pvag_pkg::SUM_W + 1;
  localparam int QW1     = pvag_pkg::SQ_W + 1;
  localparam int CSUM_W  = pvag_pkg::PCNT_W + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // sample decode and square
  logic        [SX-1:0]          samp_ext;
  logic signed [SAMPLE_BITS-1:0] samp_s;
  logic        [SAMPLE_BITS-1:0] samp_mag;
  logic        [SQ_BITS-1:0]     samp_sq;

  // operand stage
  logic                                s1_valid;
  logic                                s1_last;
  logic signed [pvag_pkg::SUM_W-1:0]   s1_sum;
  logic        [pvag_pkg::SQ_W-1:0]    s1_sq;
  logic        [pvag_pkg::PCNT_W-1:0]  s1_cnt;

  // accumulators
  logic signed [pvag_pkg::SUM_W-1:0]   sum_acc;
  logic        [pvag_pkg::SQ_W-1:0]    sumsq_acc;
  logic        [COUNT_BITS-1:0]        count_acc;
  logic                                ovf_flag;
  logic signed [SW1-1:0]               sum_wide;
  logic        [pvag_pkg::SUM_W-1:0]   sum_sat;
  logic        [QW1-1:0]               sq_wide;
  logic        [pvag_pkg::SQ_W-1:0]    sq_sat;
  logic        [CSUM_W-1:0]            cnt_wide;
  logic                                cnt_over;

  // finalize
  logic        [pvag_pkg::SUM_W-1:0]   abs_sum;
  logic        [COUNT_BITS-1:0]        n_r;
  logic        [pvag_pkg::SQ_W-1:0]    sq_r;
  logic                                ovf_r;
  logic                                nul_r;
  logic        [pvag_pkg::PROD_W-1:0]  prod;
  logic        [pvag_pkg::PROD_W-1:0]  mcand;
  logic        [pvag_pkg::SUM_W-1:0]   mplier;
  logic        [pvag_pkg::PROD_W-1:0]  quo;
  logic        [pvag_pkg::PROD_W-1:0]  q_clamp;
  logic        [pvag_pkg::DIFF_W-1:0]  sq_ext;
  logic        [pvag_pkg::DIFF_W-1:0]  qc_n;
  logic        [pvag_pkg::DIFF_W-1:0]  mdiff;
  logic        [pvag_pkg::PROD_W-1:0]  dvd_in;

  assign samp_ext = SX'($unsigned(sample));
  assign samp_s   = samp_ext[SAMPLE_BITS-1:0];
  assign samp_mag = samp_s[SAMPLE_BITS-1] ? $unsigned(-samp_s) : samp_ext[SAMPLE_BITS-1:0];
  assign samp_sq  = SQ_BITS'(samp_mag) * SQ_BITS'(samp_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= cmd.accept;
      s1_last  <= cmd.accept && last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (req_type == pvag_pkg::REQ_MERGE) begin
        s1_sum <= part_sum;
        s1_sq  <= part_sumsq;
        s1_cnt <= part_count;
      end else if (sample_null) begin
        s1_sum <= '0;
        s1_sq  <= '0;
        s1_cnt <= '0;
      end else begin
        s1_sum <= pvag_pkg::SUM_W'(samp_s);
        s1_sq  <= pvag_pkg::SQ_W'(samp_sq);
        s1_cnt <= pvag_pkg::PCNT_W'(1);
      end
    end
  end

  assign sum_wide = SW1'(s1_sum) + SW1'(sum_acc);
  assign sum_sat  = (sum_wide[SW1-1] != sum_wide[SW1-2])
                    ? (sum_wide[SW1-1] ? pvag_pkg::SUM_MIN : pvag_pkg::SUM_MAX)
                    : sum_wide[SW1-2:0];
  assign sq_wide  = QW1'(s1_sq) + QW1'(sumsq_acc);
  assign sq_sat   = sq_wide[QW1-1] ? '1 : sq_wide[QW1-2:0];
  assign cnt_wide = CSUM_W'(count_acc) + CSUM_W'(s1_cnt);
  assign cnt_over = cnt_wide > CSUM_W'(CNT_MAX);

  always_ff @(posedge clk) begin
    if (rst || cmd.snap) begin
      sum_acc   <= '0;
      sumsq_acc <= '0;
      count_acc <= '0;
      ovf_flag  <= 1'b0;
    end else if (s1_valid) begin
      sum_acc   <= sum_sat;
      sumsq_acc <= sq_sat;
      count_acc <= cnt_over ? CNT_MAX : cnt_wide[COUNT_BITS-1:0];
      ovf_flag  <= ovf_flag || cnt_over;
    end
  end

  assign stat.s1_valid = s1_valid;
  assign stat.s1_last  = s1_last;
  assign stat.cnt_zero = (count_acc == '0);

  assign abs_sum = sum_acc[pvag_pkg::SUM_W-1] ? $unsigned(-sum_acc) : $unsigned(sum_acc);

  // snapshot and shift-add square of |sum|
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      n_r    <= count_acc;
      sq_r   <= sumsq_acc;
      ovf_r  <= ovf_flag;
      nul_r  <= (count_acc == '0);
      prod   <= '0;
      mcand  <= pvag_pkg::PROD_W'(abs_sum);
      mplier <= abs_sum;
    end else if (cmd.mul_step) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign q_clamp = (quo > pvag_pkg::Q_LIMIT) ? pvag_pkg::Q_LIMIT : quo;
  assign qc_n    = q_clamp[pvag_pkg::DIFF_W-1:0];
  assign sq_ext  = pvag_pkg::DIFF_W'(sq_r);
  assign mdiff   = (sq_ext >= qc_n) ? (sq_ext - qc_n) : (qc_n - sq_ext);
  assign dvd_in  = cmd.div_load_sq ? prod : pvag_pkg::PROD_W'(mdiff);

  pvag_div #(
    .DVD_W (pvag_pkg::PROD_W),
    .DVS_W (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .load     (cmd.div_load_sq || cmd.div_load_m),
    .step     (cmd.div_step),
    .dividend (dvd_in),
    .divisor  (n_r),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (nul_r) begin
        variance <= '0;
      end else if (quo > pvag_pkg::PROD_W'(pvag_pkg::VAR_MAX)) begin
        variance <= pvag_pkg::VAR_MAX;
      end else begin
        variance <= quo[pvag_pkg::VAR_W-1:0];
      end
      no_samples <= nul_r;
      overflow   <= ovf_r;
    end
  end

  `PVAG_ASSERT_IMP(a_snap_drained, clk, rst, cmd.snap, !s1_valid)
  `PVAG_ASSERT_NXT(a_snap_clears, clk, rst, cmd.snap, count_acc == '0 && !ovf_flag)
  `PVAG_ASSERT_IMP(a_div_nonzero, clk, rst, cmd.div_step, n_r != '0)

endmodule

[rtl/core/population_variance_aggregate_top.sv]
// ----------------------------------------------------------------------------
// Population variance aggregate - top level
// Running sum / sum of squares / count with a variance result per group.
//
// Channels: item (sink) takes samples (req_type 0) or partial aggregates
// (req_type 1); result (source) gives one variance per item marked last.
// A transaction completes on a rising edge with valid and ready both high.
// Items are taken one per cycle while a group accumulates. After the last
// item, item.ready stays low while the result is computed: the last item is
// accumulated, the accumulators are snapshot, |sum| is squared by shift-add,
// then two restoring divides by the count run (one quotient bit per cycle
// each), each after a divider load, and the result is loaded. A group with
// no samples goes from the snapshot straight to the result load.
// Reset (rst, synchronous) clears the accumulators, the overflow flag and
// the result valid. A stalled result register does not block the next group
// from accumulating; only the result load of that next group waits for it.
// ----------------------------------------------------------------------------
module population_variance_aggregate_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  pvag_in_if.sink     item,
  pvag_out_if.source  result
);

  pvag_pkg::ctrl_cmd_t cmd;
  pvag_pkg::dp_stat_t  stat;
  logic                in_ready;
  logic                out_valid;

  assign item.ready   = in_ready;
  assign result.valid = out_valid;

  pvag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (in_ready),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  pvag_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (item.req_type),
    .sample      (item.sample),
    .sample_null (item.sample_null),
    .part_sum    (item.part_sum),
    .part_sumsq  (item.part_sumsq),
    .part_count  (item.part_count),
    .last        (item.last),
    .variance    (result.variance),
    .no_samples  (result.no_samples),
    .overflow    (result.overflow)
  );

endmodule

[tb/sv/population_variance_aggregate_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Population variance aggregate - testbench
// Streams sample and merge transactions in groups closed by a last marker.
// A scoreboard keeps its own running sum, sum of squares and count and
// checks each variance result field by field. Both channels idle at random,
// and the result side holds off once for a long stretch so the block stalls.
// ----------------------------------------------------------------------------
module population_variance_aggregate_top_tb;

  localparam int          SAMP_W    = pvag_pkg::SAMP_W;
  localparam int          SUM_W     = pvag_pkg::SUM_W;
  localparam int          SQ_W      = pvag_pkg::SQ_W;
  localparam int          PCNT_W    = pvag_pkg::PCNT_W;
  localparam int          VAR_W     = pvag_pkg::VAR_W;
  localparam int          CNT_W     = 24;
  localparam int          N_ITEMS   = 1050;
  localparam int          DRAIN     = 300;
  localparam int          HOLD_LEN  = 3000;
  localparam int          SHOW_MAX  = 10;
  localparam longint      SUM_HI    = longint'($signed(pvag_pkg::SUM_MAX));
  localparam longint      SUM_LO    = longint'($signed(pvag_pkg::SUM_MIN));
  localparam logic [SQ_W-1:0]  SQ_TOP  = {SQ_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

  typedef struct packed {
    logic                     req_type;
    logic signed [SAMP_W-1:0] sample;
    logic                     sample_null;
    logic signed [SUM_W-1:0]  part_sum;
    logic [SQ_W-1:0]          part_sumsq;
    logic [PCNT_W-1:0]        part_count;
    logic                     last;
  } pvag_item_t;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic             no_samples;
    logic             overflow;
  } var_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pvag_in_if  item_ch ();
  pvag_out_if res_ch ();

  population_variance_aggregate_top #(
    .SAMPLE_BITS(SAMP_W),
    .COUNT_BITS (CNT_W)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(res_ch)
  );

  always #5 clk = ~clk;

  pvag_item_t pending_items[$];
  var_res_t   var_expect[$];
  pvag_item_t cur_item;

  logic signed [SUM_W-1:0] acc_sum = '0;
  logic [SQ_W-1:0]         acc_sq  = '0;
  logic [CNT_W-1:0]        acc_cnt = '0;
  logic                    acc_ovf = 1'b0;

  int unsigned in_gap   = 0;
  int unsigned out_gap  = 0;
  int unsigned calm_in  = 0;
  int unsigned calm_out = 0;
  int unsigned err_cnt  = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;

  // ---------------- running aggregate ----------------
  function automatic void acc_add(longint s_add, logic [SQ_W-1:0] sq_add,
                                  logic [PCNT_W-1:0] c_add);
    longint           s_new;
    logic [SQ_W:0]    sq_new;
    logic [CNT_W:0]   c_new;
    s_new = longint'(acc_sum) + s_add;
    if (s_new > SUM_HI) s_new = SUM_HI;
    if (s_new < SUM_LO) s_new = SUM_LO;
    acc_sum = SUM_W'(s_new);
    sq_new = {1'b0, acc_sq} + (SQ_W+1)'(sq_add);
    acc_sq = (sq_new > (SQ_W+1)'(SQ_TOP)) ? SQ_TOP : sq_new[SQ_W-1:0];
    c_new = {1'b0, acc_cnt} + (CNT_W+1)'(c_add[CNT_W-1:0]);
    if (c_new > (CNT_W+1)'(CNT_TOP)) begin
      acc_cnt = CNT_TOP;
      acc_ovf = 1'b1;
    end else begin
      acc_cnt = c_new[CNT_W-1:0];
    end
  endfunction

  function automatic void fold_item(pvag_item_t it);
    longint       sv;
    longint       mag_s;
    logic [127:0] mag, n, q, m, v, sq_w;
    var_res_t     r;
    if (it.req_type == pvag_pkg::REQ_SAMPLE) begin
      if (!it.sample_null) begin
        sv = longint'($signed(it.sample));
        mag_s = (sv < 0) ? -sv : sv;
        acc_add(sv, SQ_W'(mag_s * mag_s), PCNT_W'(1));
      end
    end else begin
      acc_add(longint'($signed(it.part_sum)), it.part_sumsq, it.part_count);
    end
    if (!it.last) return;
    r = '0;
    r.overflow = acc_ovf;
    if (acc_cnt == '0) begin
      r.no_samples = 1'b1;
    end else begin
      n = 128'(acc_cnt);
      sv = longint'(acc_sum);
      mag = 128'((sv < 0) ? -sv : sv);
      q = (mag * mag) / n;
      if (q > 128'(pvag_pkg::Q_LIMIT)) q = 128'(pvag_pkg::Q_LIMIT);
      sq_w = 128'(acc_sq);
      m = (sq_w >= q) ? sq_w - q : q - sq_w;
      v = m / n;
      r.variance = (v > 128'(pvag_pkg::VAR_MAX)) ? pvag_pkg::VAR_MAX : v[VAR_W-1:0];
    end
    var_expect.push_back(r);
    acc_sum = '0;
    acc_sq  = '0;
    acc_cnt = '0;
    acc_ovf = 1'b0;
  endfunction

  // ---------------- stimulus ----------------
  function automatic pvag_item_t rand_item();
    pvag_item_t it;
    it.req_type    = 1'($urandom_range(0, 1));
    it.sample      = SAMP_W'($urandom);
    it.sample_null = 1'($urandom_range(0, 1));
    it.part_sum    = SUM_W'({$urandom, $urandom});
    it.part_sumsq  = SQ_W'({$urandom, $urandom});
    it.part_count  = PCNT_W'($urandom);
    it.last        = 1'b0;
    return it;
  endfunction

  function automatic pvag_item_t mk_sample(logic signed [SAMP_W-1:0] val, logic nul,
                                           logic lst);
    pvag_item_t it;
    it = rand_item();
    it.req_type    = pvag_pkg::REQ_SAMPLE;
    it.sample      = val;
    it.sample_null = nul;
    it.last        = lst;
    return it;
  endfunction

  function automatic pvag_item_t mk_merge(logic signed [SUM_W-1:0] ps, logic [SQ_W-1:0] pq,
                                          logic [PCNT_W-1:0] pc, logic lst);
    pvag_item_t it;
    it = rand_item();
    it.req_type   = pvag_pkg::REQ_MERGE;
    it.part_sum   = ps;
    it.part_sumsq = pq;
    it.part_count = pc;
    it.last       = lst;
    return it;
  endfunction

  function automatic logic signed [SAMP_W-1:0] draw_sample(int unsigned mode, int base);
    case (mode)
      0:       return SAMP_W'($urandom);
      1:       return SAMP_W'(int'($urandom_range(0, 510)) - 255);
      2:       return SAMP_W'(base + int'($urandom_range(0, 6)) - 3);
      default: return $urandom_range(0, 1) ? SAMP_W'(16'sh7fff) : SAMP_W'(16'sh8000);
    endcase
  endfunction

  task automatic load_directed();
    // empty group, and a merge that brings sums but no count
    pending_items.push_back(mk_sample('0, 1'b1, 1'b1));
    pending_items.push_back(mk_merge(SUM_W'(12345), SQ_W'(999), '0, 1'b1));
    // sample extremes, null closing the group
    pending_items.push_back(mk_sample(16'sh7fff, 1'b0, 1'b0));
    pending_items.push_back(mk_sample(16'sh8000, 1'b0, 1'b0));
    pending_items.push_back(mk_sample('0, 1'b0, 1'b0));
    pending_items.push_back(mk_sample(16'sh1234, 1'b1, 1'b1));
    // sums clamp high
    pending_items.push_back(mk_merge(pvag_pkg::SUM_MAX, SQ_TOP, PCNT_W'(1), 1'b0));
    pending_items.push_back(mk_merge(pvag_pkg::SUM_MAX, SQ_TOP, PCNT_W'(1), 1'b0));
    pending_items.push_back(mk_sample(SAMP_W'(100), 1'b0, 1'b1));
    // sum clamps low
    pending_items.push_back(mk_merge(pvag_pkg::SUM_MIN, '0, PCNT_W'(2), 1'b0));
    pending_items.push_back(mk_merge(pvag_pkg::SUM_MIN, '0, PCNT_W'(2), 1'b1));
    // inconsistent partials, variance clamp
    pending_items.push_back(mk_merge('0, SQ_TOP, PCNT_W'(1), 1'b1));
    // count at its top without saturating
    pending_items.push_back(mk_merge(SUM_W'(100), SQ_W'(10000), CNT_TOP, 1'b1));
    // count saturation, then a clean group
    pending_items.push_back(mk_merge('0, '0, CNT_TOP, 1'b0));
    pending_items.push_back(mk_sample(-SAMP_W'(1), 1'b0, 1'b1));
    pending_items.push_back(mk_sample(SAMP_W'(256), 1'b0, 1'b0));
    pending_items.push_back(mk_sample(SAMP_W'(512), 1'b0, 1'b1));
  endtask

  task automatic add_group();
    int unsigned r, len, mode, k, i, j;
    int          base;
    logic        all_null;
    longint      ps;
    longint      pq;
    longint      sv;
    r = $urandom_range(0, 99);
    len = (r < 70) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 30)
                                                     : $urandom_range(31, 120);
    mode = $urandom_range(0, 9);
    mode = (mode < 4) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
    base = int'($urandom_range(0, 65535)) - 32768;
    all_null = ($urandom_range(0, 99) < 3);
    for (i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (all_null) begin
        pending_items.push_back(mk_sample(draw_sample(0, 0), 1'b1, i == len - 1));
      end else if (r < 72) begin
        pending_items.push_back(mk_sample(draw_sample(mode, base),
                                          $urandom_range(0, 9) == 0, i == len - 1));
      end else if (r < 90) begin
        k = $urandom_range(0, 16);
        ps = 0;
        pq = 0;
        for (j = 0; j < k; j++) begin
          sv = longint'(draw_sample(mode, base));
          ps += sv;
          pq += sv * sv;
        end
        pending_items.push_back(mk_merge(SUM_W'(ps), SQ_W'(pq), PCNT_W'(k), i == len - 1));
      end else if (r < 97) begin
        pending_items.push_back(mk_merge(SUM_W'({$urandom, $urandom}),
                                         SQ_W'({$urandom, $urandom}),
                                         PCNT_W'($urandom), i == len - 1));
      end else begin
        pending_items.push_back(mk_merge(SUM_W'($urandom), SQ_W'({$urandom, $urandom}),
                                         PCNT_W'($urandom_range(CNT_TOP - 63, CNT_TOP)),
                                         i == len - 1));
      end
    end
  endtask

  function automatic int unsigned pick_gap(ref int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 199) == 0) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin : drv
    logic take;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      take = item_ch.valid && item_ch.ready;
      if (take) fold_item(cur_item);
      if (!item_ch.valid || take) begin
        if (in_gap > 0) begin
          in_gap--;
          item_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          item_ch.req_type    <= cur_item.req_type;
          item_ch.sample      <= cur_item.sample;
          item_ch.sample_null <= cur_item.sample_null;
          item_ch.part_sum    <= cur_item.part_sum;
          item_ch.part_sumsq  <= cur_item.part_sumsq;
          item_ch.part_count  <= cur_item.part_count;
          item_ch.last        <= cur_item.last;
          item_ch.valid       <= 1'b1;
          in_gap = pick_gap(calm_in);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin : mon
    var_res_t got;
    var_res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.variance   = res_ch.variance;
        got.no_samples = res_ch.no_samples;
        got.overflow   = res_ch.overflow;
        results_seen <= results_seen + 1;
        if (var_expect.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("unexpected result: variance=%0d no_samples=%0b overflow=%0b",
                     got.variance, got.no_samples, got.overflow);
        end else begin
          want = var_expect.pop_front();
          if (got.variance !== want.variance || got.no_samples !== want.no_samples ||
              got.overflow !== want.overflow) begin
            err_cnt++;
            if (err_cnt <= SHOW_MAX)
              $display("mismatch: exp var=%0d nul=%0b ovf=%0b, got var=%0d nul=%0b ovf=%0b",
                       want.variance, want.no_samples, want.overflow,
                       got.variance, got.no_samples, got.overflow);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= (hold_left == 0);
        out_gap = pick_gap(calm_out);
      end
    end
  end

  // long result hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= 20) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------- sequence ----------------
  initial begin
    item_ch.valid       = 1'b0;
    item_ch.req_type    = pvag_pkg::REQ_SAMPLE;
    item_ch.sample      = '0;
    item_ch.sample_null = 1'b0;
    item_ch.part_sum    = '0;
    item_ch.part_sumsq  = '0;
    item_ch.part_count  = '0;
    item_ch.last        = 1'b0;
    res_ch.ready        = 1'b0;
    load_directed();
    while (pending_items.size() < N_ITEMS) add_group();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (pending_items.size() != 0 || item_ch.valid);
    while (var_expect.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (err_cnt == 0 && var_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
